@@ src/rrqs_pkg.sv @@
package rrqs_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_TASKS_DEF  = 16;
  localparam int unsigned TIME_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int unsigned MODE_W     = 1;
  localparam int unsigned TASK_IDX_W = 4;
  localparam int unsigned FIELD_T_W  = 16;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned QUANTUM_W  = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM    = 1'b1;

  // Configuration reset values
  localparam logic [COUNT_W-1:0]   TASK_COUNT_RST = 5'd1;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RST    = 16'd2;

  // Input item modes
  localparam logic [MODE_W-1:0] MODE_LOAD = 1'b0;
  localparam logic [MODE_W-1:0] MODE_TICK = 1'b1;

  typedef struct packed {
    logic load;
    logic retire;
    logic mod_step;
    logic scan_step;
    logic apply;
    logic run;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sel_need;
    logic mod_done;
    logic scan_end;
    logic out_free;
  } status_t;

endpackage

@@ src/rrqs_ram.sv @@
module rrqs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rrqs_ctrl.sv @@
module rrqs_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [rrqs_pkg::MODE_W-1:0]  mode_i,
  output logic                         in_stall_o,
  input  rrqs_pkg::status_t            status_i,
  output rrqs_pkg::cmd_t               cmd_o
);
  import rrqs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RD     = 9'b000000010,
    S_RET    = 9'b000000100,
    S_MOD    = 9'b000001000,
    S_SCAN   = 9'b000010000,
    S_APPLY  = 9'b000100000,
    S_RUN_RD = 9'b001000000,
    S_RUN    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept     = (state_q == S_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_RET;
      end
      S_RET: begin
        cmd_o.retire = 1'b1;
        state_d      = status_i.sel_need ? S_MOD : S_RUN_RD;
      end
      S_MOD: begin
        // wrap the first candidate into the entries in use
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_done) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_end) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_RUN_RD;
      end
      S_RUN_RD: begin
        state_d = S_RUN;
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        // hold until the output register can take the transaction
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/rrqs_dp.sv @@
module rrqs_dp #(
  parameter int unsigned MAX_TASKS  = rrqs_pkg::MAX_TASKS_DEF,
  parameter int unsigned TIME_WIDTH = rrqs_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rrqs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rrqs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [rrqs_pkg::TASK_IDX_W-1:0]  task_index_i,
  input  logic [rrqs_pkg::FIELD_T_W-1:0]   arrival_time_i,
  input  logic [rrqs_pkg::FIELD_T_W-1:0]   burst_length_i,
  input  rrqs_pkg::cmd_t                   cmd_i,
  output rrqs_pkg::status_t                status_o,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [rrqs_pkg::FIELD_T_W-1:0]   tick_number_o,
  output logic                             busy_res_o,
  output logic [rrqs_pkg::TASK_IDX_W-1:0]  running_task_o,
  output logic                             retired_valid_o,
  output logic [rrqs_pkg::TASK_IDX_W-1:0]  retired_task_o,
  output logic [rrqs_pkg::FIELD_T_W-1:0]   completion_time_o,
  output logic [rrqs_pkg::FIELD_T_W-1:0]   turnaround_time_o,
  output logic [rrqs_pkg::FIELD_T_W-1:0]   waiting_time_o,
  output logic [rrqs_pkg::FIELD_T_W-1:0]   response_time_o,
  output logic                             all_done_o
);
  import rrqs_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam int unsigned CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned LDX_W = (CNT_W > TASK_IDX_W) ? CNT_W : TASK_IDX_W;

  typedef logic [TIME_WIDTH-1:0] time_t;

  // configuration
  logic [COUNT_W-1:0]   task_count_q;
  logic [QUANTUM_W-1:0] quantum_q;
  logic [CNT_W-1:0]     n_used;
  logic [QUANTUM_W-1:0] q_used;

  // schedule state
  time_t                tick_q;
  logic [IDX_W-1:0]     ptr_q;
  logic                 run_q;
  logic [QUANTUM_W-1:0] qleft_q;
  logic [MAX_TASKS-1:0] burst_nz_q, burst_nz_d;
  logic [MAX_TASKS-1:0] has_work_q, has_work_d;
  logic [MAX_TASKS-1:0] started_q, started_d;

  // selection scan
  logic [CNT_W-1:0]     cand_q;
  logic [CNT_W-1:0]     issued_q;
  logic                 chk_valid_q;
  logic                 chk_hw_q;
  logic [IDX_W-1:0]     chk_idx_q;
  logic                 found_q;
  logic [IDX_W-1:0]     found_idx_q;
  logic                 any_q;

  // result staging
  logic                 ret_q;
  logic [TASK_IDX_W-1:0] r_task_q;
  time_t                ct_q, tat_q, wt_q, rt_q;
  logic                 done_q;
  logic                 res_busy_q;
  logic [TASK_IDX_W-1:0] res_task_q;
  time_t                res_tick_q;
  logic                 out_valid_q;

  // memory ports
  time_t                arr_rdata, burst_rdata, rem_rdata, fr_rdata;
  logic [IDX_W-1:0]     arr_raddr;
  logic                 load_ok;
  logic [IDX_W-1:0]     load_idx;
  time_t                arr_in, burst_in;
  logic                 rem_we, fr_we;
  time_t                cur_rem, tat_new;

  // retire and scan helpers
  logic                 ret_hit;
  logic                 run_ret;
  logic [QUANTUM_W-1:0] qleft_ret;
  logic [IDX_W-1:0]     cand_idx;
  logic                 issue_done;
  logic                 hit;
  logic                 out_free;

  // -------------------------------------------------------------------------
  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= TASK_COUNT_RST;
      quantum_q    <= QUANTUM_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TASK_COUNT: task_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_QUANTUM:    quantum_q    <= cfg_data_i[QUANTUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (task_count_q == '0) begin
      n_used = CNT_W'(1);
    end else if (CMP_W'(task_count_q) > CMP_W'(MAX_TASKS)) begin
      n_used = CNT_W'(MAX_TASKS);
    end else begin
      n_used = CNT_W'(task_count_q);
    end
  end

  assign q_used = (quantum_q == '0) ? QUANTUM_W'(1) : quantum_q;

  // -------------------------------------------------------------------------
  // entry stores
  assign load_ok  = LDX_W'(task_index_i) < LDX_W'(MAX_TASKS);
  assign load_idx = IDX_W'(task_index_i);
  assign arr_in   = TIME_WIDTH'(arrival_time_i);
  assign burst_in = TIME_WIDTH'(burst_length_i);

  assign arr_raddr = cmd_i.scan_step ? cand_idx : ptr_q;

  // a task that has not started yet still has its whole burst left
  assign cur_rem = started_q[ptr_q] ? rem_rdata : burst_rdata;
  assign rem_we  = cmd_i.run && run_q && has_work_q[ptr_q];
  assign fr_we   = cmd_i.run && run_q && !started_q[ptr_q];

  rrqs_ram #(.WIDTH(TIME_WIDTH), .DEPTH(MAX_TASKS)) u_arr_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && load_ok),
    .waddr_i (load_idx),
    .wdata_i (arr_in),
    .raddr_i (arr_raddr),
    .rdata_o (arr_rdata)
  );

  rrqs_ram #(.WIDTH(TIME_WIDTH), .DEPTH(MAX_TASKS)) u_burst_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && load_ok),
    .waddr_i (load_idx),
    .wdata_i (burst_in),
    .raddr_i (ptr_q),
    .rdata_o (burst_rdata)
  );

  rrqs_ram #(.WIDTH(TIME_WIDTH), .DEPTH(MAX_TASKS)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (ptr_q),
    .wdata_i (cur_rem - TIME_WIDTH'(1)),
    .raddr_i (ptr_q),
    .rdata_o (rem_rdata)
  );

  rrqs_ram #(.WIDTH(TIME_WIDTH), .DEPTH(MAX_TASKS)) u_fr_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (ptr_q),
    .wdata_i (tick_q),
    .raddr_i (ptr_q),
    .rdata_o (fr_rdata)
  );

  // -------------------------------------------------------------------------
  // per-entry flags
  always_comb begin
    burst_nz_d = burst_nz_q;
    has_work_d = has_work_q;
    started_d  = started_q;
    if (cmd_i.load && load_ok) begin
      burst_nz_d[load_idx] = (burst_in != '0);
    end
    if (cmd_i.load) begin
      has_work_d = burst_nz_d;
      started_d  = '0;
    end
    if (rem_we) begin
      has_work_d[ptr_q] = (cur_rem != TIME_WIDTH'(1));
    end
    if (fr_we) begin
      started_d[ptr_q] = 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // retire
  assign ret_hit   = run_q && !has_work_q[ptr_q];
  assign run_ret   = run_q && !ret_hit;
  assign qleft_ret = !run_q ? qleft_q : (ret_hit ? q_used : qleft_q - QUANTUM_W'(1));
  assign tat_new   = tick_q - arr_rdata;

  // scan
  assign cand_idx   = IDX_W'(cand_q);
  assign issue_done = (issued_q == n_used);
  assign hit        = chk_valid_q && chk_hw_q && (arr_rdata <= tick_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign status_o.sel_need = (qleft_ret == '0) || !run_ret;
  assign status_o.mod_done = (cand_q < n_used);
  assign status_o.scan_end = hit || (issue_done && !chk_valid_q);
  assign status_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      ptr_q       <= '0;
      run_q       <= 1'b0;
      qleft_q     <= QUANTUM_RST;
      burst_nz_q  <= '0;
      has_work_q  <= '0;
      started_q   <= '0;
      cand_q      <= '0;
      issued_q    <= '0;
      chk_valid_q <= 1'b0;
      found_q     <= 1'b0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      burst_nz_q <= burst_nz_d;
      has_work_q <= has_work_d;
      started_q  <= started_d;

      if (cmd_i.load) begin
        tick_q  <= '0;
        ptr_q   <= IDX_W'(n_used - CNT_W'(1));
        run_q   <= 1'b0;
        qleft_q <= q_used;
      end

      if (cmd_i.retire) begin
        run_q       <= run_ret;
        qleft_q     <= qleft_ret;
        cand_q      <= CNT_W'(ptr_q) + CNT_W'(1);
        issued_q    <= '0;
        chk_valid_q <= 1'b0;
        found_q     <= 1'b0;
        any_q       <= 1'b0;
      end

      if (cmd_i.mod_step && (cand_q >= n_used)) begin
        cand_q <= cand_q - n_used;
      end

      if (cmd_i.scan_step) begin
        if (!issue_done) begin
          chk_valid_q <= 1'b1;
          issued_q    <= issued_q + CNT_W'(1);
          cand_q      <= (cand_q + CNT_W'(1) == n_used) ? '0 : cand_q + CNT_W'(1);
        end else begin
          chk_valid_q <= 1'b0;
        end
        if (hit) begin
          found_q <= 1'b1;
        end
        any_q <= any_q || (chk_valid_q && chk_hw_q);
      end

      if (cmd_i.apply) begin
        if (found_q) begin
          ptr_q   <= found_idx_q;
          run_q   <= 1'b1;
          qleft_q <= q_used;
        end else if (any_q) begin
          run_q   <= 1'b0;
          qleft_q <= q_used;
        end
      end

      if (cmd_i.run) begin
        tick_q <= tick_q + TIME_WIDTH'(1);
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      if (!issue_done) begin
        chk_idx_q <= cand_idx;
        chk_hw_q  <= has_work_q[cand_idx];
      end
      if (hit) begin
        found_idx_q <= chk_idx_q;
      end
    end

    if (cmd_i.retire) begin
      ret_q    <= ret_hit;
      r_task_q <= ret_hit ? TASK_IDX_W'(ptr_q) : '0;
      ct_q     <= ret_hit ? tick_q : '0;
      tat_q    <= ret_hit ? tat_new : '0;
      wt_q     <= ret_hit ? tat_new - burst_rdata : '0;
      rt_q     <= ret_hit ? fr_rdata - arr_rdata : '0;
      done_q   <= 1'b0;
    end

    if (cmd_i.apply) begin
      done_q <= !found_q && !any_q && !run_q;
    end

    if (cmd_i.run) begin
      res_busy_q <= run_q;
      res_task_q <= run_q ? TASK_IDX_W'(ptr_q) : '0;
      res_tick_q <= tick_q;
    end

    if (cmd_i.out_load) begin
      tick_number_o     <= FIELD_T_W'(res_tick_q);
      busy_res_o        <= res_busy_q;
      running_task_o    <= res_task_q;
      retired_valid_o   <= ret_q;
      retired_task_o    <= r_task_q;
      completion_time_o <= FIELD_T_W'(ct_q);
      turnaround_time_o <= FIELD_T_W'(tat_q);
      waiting_time_o    <= FIELD_T_W'(wt_q);
      response_time_o   <= FIELD_T_W'(rt_q);
      all_done_o        <= done_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/round_robin_quantum_scheduler_unit.sv @@
// Channel  Direction  Handshake                    Payload
// in       input      in_valid_i / in_stall_o      mode, task_index, arrival_time, burst_length
// out      output     out_valid_o / out_stall_i    tick stats, retired task stats, all_done
// cfg      input      cfg_we_i (no wait)           cfg_index_i, cfg_data_i
//
// A load gives no result. A tick reads and retires the running entry; when a reselection is
// needed, it wraps the first candidate into the entries in use (n = entries in use) and then
// runs the arrival scan at one entry per cycle; after that it runs and loads the output register.
// Reset clears the control state; the entry memories hold nothing until loaded.
// A stalled result stays in the output register while the next item is taken; the next
// result waits until it leaves.
module round_robin_quantum_scheduler_unit #(
  parameter int unsigned MAX_TASKS  = rrqs_pkg::MAX_TASKS_DEF,
  parameter int unsigned TIME_WIDTH = rrqs_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rrqs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rrqs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rrqs_pkg::MODE_W-1:0]      mode_i,
  input  logic [rrqs_pkg::TASK_IDX_W-1:0]  task_index_i,
  input  logic [rrqs_pkg::FIELD_T_W-1:0]   arrival_time_i,
  input  logic [rrqs_pkg::FIELD_T_W-1:0]   burst_length_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rrqs_pkg::FIELD_T_W-1:0]   tick_number_o,
  output logic                             busy_res_o,
  output logic [rrqs_pkg::TASK_IDX_W-1:0]  running_task_o,
  output logic                             retired_valid_o,
  output logic [rrqs_pkg::TASK_IDX_W-1:0]  retired_task_o,
  output logic [rrqs_pkg::FIELD_T_W-1:0]   completion_time_o,
  output logic [rrqs_pkg::FIELD_T_W-1:0]   turnaround_time_o,
  output logic [rrqs_pkg::FIELD_T_W-1:0]   waiting_time_o,
  output logic [rrqs_pkg::FIELD_T_W-1:0]   response_time_o,
  output logic                             all_done_o
);
  import rrqs_pkg::*;

  cmd_t    cmd;
  status_t status;

  rrqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrqs_dp #(
    .MAX_TASKS  (MAX_TASKS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .task_index_i      (task_index_i),
    .arrival_time_i    (arrival_time_i),
    .burst_length_i    (burst_length_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .tick_number_o     (tick_number_o),
    .busy_res_o        (busy_res_o),
    .running_task_o    (running_task_o),
    .retired_valid_o   (retired_valid_o),
    .retired_task_o    (retired_task_o),
    .completion_time_o (completion_time_o),
    .turnaround_time_o (turnaround_time_o),
    .waiting_time_o    (waiting_time_o),
    .response_time_o   (response_time_o),
    .all_done_o        (all_done_o)
  );

endmodule

@@ verif/round_robin_quantum_scheduler_unit_test.sv @@
module round_robin_quantum_scheduler_unit_test;
  import rrqs_pkg::*;

  localparam int unsigned NUM_TASKS     = MAX_TASKS_DEF;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned RANDOM_ITEMS  = 1700;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam int unsigned TIMEOUT       = 2000000;

  typedef logic [MODE_W-1:0]     mode_t;
  typedef logic [TASK_IDX_W-1:0] task_t;
  typedef logic [FIELD_T_W-1:0]  time_t;

  typedef struct packed {
    time_t tick_no;
    logic  busy;
    task_t run_task;
    logic  ret_valid;
    task_t ret_task;
    time_t compl;
    time_t turn;
    time_t waiting;
    time_t resp;
    logic  all_done;
  } tick_report_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_TICK} row_kind_e;

  // sel is the task index of a load or the register index of a write;
  // a carries arrival time or register data, b the burst length
  typedef struct packed {
    row_kind_e    kind;
    task_t        sel;
    time_t        a;
    time_t        b;
    logic         typed;
    tick_report_t want;
  } plan_row_t;

  localparam plan_row_t TICK_ROW = '{ROW_TICK, 4'd0, 16'd0, 16'd0, 1'b0, '0};

  localparam plan_row_t DIRECTED_PLAN [29] = '{
    // single task, reset quantum of two: run, run, retire, idle
    '{ROW_LOAD, 4'd0, 16'd0, 16'd2, 1'b0, '0},
    '{ROW_TICK, 4'd0, 16'd0, 16'd0, 1'b1,
      '{16'd0, 1'b1, 4'd0, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{ROW_TICK, 4'd0, 16'd0, 16'd0, 1'b1,
      '{16'd1, 1'b1, 4'd0, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{ROW_TICK, 4'd0, 16'd0, 16'd0, 1'b1,
      '{16'd2, 1'b0, 4'd0, 1'b1, 4'd0, 16'd2, 16'd2, 16'd0, 16'd0, 1'b1}},
    '{ROW_TICK, 4'd0, 16'd0, 16'd0, 1'b1,
      '{16'd3, 1'b0, 4'd0, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
    // zero quantum and zero count
    '{ROW_CFG, CFG_QUANTUM, 16'd0, 16'd0, 1'b0, '0},
    '{ROW_CFG, CFG_TASK_COUNT, 16'd0, 16'd0, 1'b0, '0},
    '{ROW_LOAD, 4'd1, 16'hFFFF, 16'hFFFF, 1'b0, '0},
    TICK_ROW, TICK_ROW, TICK_ROW,
    // second entry never arrives: idle ticks with work left
    '{ROW_CFG, CFG_TASK_COUNT, 16'd2, 16'd0, 1'b0, '0},
    '{ROW_LOAD, 4'd0, 16'd3, 16'd1, 1'b0, '0},
    TICK_ROW, TICK_ROW, TICK_ROW, TICK_ROW, TICK_ROW,
    // count above the table size, largest quantum, zero burst
    '{ROW_CFG, CFG_TASK_COUNT, 16'd31, 16'd0, 1'b0, '0},
    '{ROW_CFG, CFG_QUANTUM, 16'hFFFF, 16'd0, 1'b0, '0},
    '{ROW_LOAD, 4'd15, 16'd0, 16'd0, 1'b0, '0},
    TICK_ROW, TICK_ROW, TICK_ROW, TICK_ROW,
    // lower the count under a running task
    '{ROW_CFG, CFG_TASK_COUNT, 16'd1, 16'd0, 1'b0, '0},
    TICK_ROW, TICK_ROW, TICK_ROW
  };

  logic          clk_i             = 1'b0;
  logic          rst_ni            = 1'b0;
  logic          cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic          in_valid_i        = 1'b0;
  logic          in_stall_o;
  mode_t         mode_i            = MODE_LOAD;
  task_t         task_index_i      = '0;
  time_t         arrival_time_i    = '0;
  time_t         burst_length_i    = '0;
  logic          out_valid_o;
  logic          out_stall_i       = 1'b0;
  time_t         tick_number_o;
  logic          busy_res_o;
  task_t         running_task_o;
  logic          retired_valid_o;
  task_t         retired_task_o;
  time_t         completion_time_o;
  time_t         turnaround_time_o;
  time_t         waiting_time_o;
  time_t         response_time_o;
  logic          all_done_o;

  round_robin_quantum_scheduler_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .task_index_i      (task_index_i),
    .arrival_time_i    (arrival_time_i),
    .burst_length_i    (burst_length_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .tick_number_o     (tick_number_o),
    .busy_res_o        (busy_res_o),
    .running_task_o    (running_task_o),
    .retired_valid_o   (retired_valid_o),
    .retired_task_o    (retired_task_o),
    .completion_time_o (completion_time_o),
    .turnaround_time_o (turnaround_time_o),
    .waiting_time_o    (waiting_time_o),
    .response_time_o   (response_time_o),
    .all_done_o        (all_done_o)
  );

  always #1 clk_i = ~clk_i;

  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 66;
  int unsigned items_sent    = 0;
  int unsigned error_count   = 0;

  tick_report_t pending_reports [$];

  // scheduler state as the block should hold it
  time_t       arrival_mem   [NUM_TASKS];
  time_t       burst_mem     [NUM_TASKS];
  time_t       remain_mem    [NUM_TASKS];
  time_t       first_run_mem [NUM_TASKS];
  logic        started_mem   [NUM_TASKS];
  time_t       tick_cnt;
  task_t       cur_task;
  logic        running;
  time_t       quantum_left;
  logic [COUNT_W-1:0]   count_reg;
  logic [QUANTUM_W-1:0] quantum_reg;

  function automatic int unsigned tasks_in_use();
    if (count_reg == 0) return 1;
    if (count_reg > NUM_TASKS) return NUM_TASKS;
    return count_reg;
  endfunction

  function automatic time_t slice_len();
    return (quantum_reg == 0) ? time_t'(1) : time_t'(quantum_reg);
  endfunction

  function automatic logic work_pending(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      if (remain_mem[i] != 0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void restart_schedule();
    for (int unsigned i = 0; i < NUM_TASKS; i++) begin
      remain_mem[i]  = burst_mem[i];
      started_mem[i] = 1'b0;
    end
    tick_cnt     = '0;
    cur_task     = task_t'(tasks_in_use() - 1);
    running      = 1'b0;
    quantum_left = slice_len();
  endfunction

  function automatic void advance_schedule(input mode_t m, input task_t idx, input time_t arr,
                                           input time_t burst, output tick_report_t rep,
                                           output logic made);
    int unsigned n;
    int unsigned cand;
    time_t       t;
    logic        found;
    rep  = '0;
    made = 1'b0;
    if (m == MODE_LOAD) begin
      arrival_mem[idx] = arr;
      burst_mem[idx]   = burst;
      restart_schedule();
      return;
    end
    n     = tasks_in_use();
    t     = tick_cnt;
    found = 1'b0;
    rep.tick_no = t;
    // retire the running task once its work is used up
    if (running) begin
      quantum_left = quantum_left - 1'b1;
      if (remain_mem[cur_task] == 0) begin
        rep.ret_valid = 1'b1;
        rep.ret_task  = cur_task;
        rep.compl     = t;
        rep.turn      = t - arrival_mem[cur_task];
        rep.waiting   = rep.turn - burst_mem[cur_task];
        rep.resp      = first_run_mem[cur_task] - arrival_mem[cur_task];
        running       = 1'b0;
        quantum_left  = slice_len();
      end
    end
    // pick the next arrived task with work, cyclically after the current one
    if ((quantum_left == 0 || !running) && work_pending(n)) begin
      running      = 1'b0;
      quantum_left = slice_len();
      for (int unsigned k = 1; k <= n && !found; k++) begin
        cand = (cur_task + k) % n;
        if (arrival_mem[cand] <= t && remain_mem[cand] != 0) begin
          cur_task = task_t'(cand);
          running  = 1'b1;
          found    = 1'b1;
        end
      end
    end
    rep.all_done = !running && !work_pending(n);
    if (running) begin
      if (!started_mem[cur_task]) begin
        started_mem[cur_task]   = 1'b1;
        first_run_mem[cur_task] = t;
      end
      if (remain_mem[cur_task] != 0) remain_mem[cur_task] = remain_mem[cur_task] - 1'b1;
      rep.busy     = 1'b1;
      rep.run_task = cur_task;
    end
    tick_cnt = t + 1'b1;
    made     = 1'b1;
  endfunction

  function automatic string report_text(input tick_report_t r);
    return $sformatf("tick %0d busy %0d run %0d retired %0d/%0d ct %0d tat %0d wt %0d rt %0d done %0d",
                     r.tick_no, r.busy, r.run_task, r.ret_valid, r.ret_task, r.compl, r.turn,
                     r.waiting, r.resp, r.all_done);
  endfunction

  // present one transaction and return at the edge that takes it
  task automatic send_item(input mode_t m, input task_t idx, input time_t arr, input time_t burst,
                           input logic typed, input tick_report_t given);
    tick_report_t predicted;
    logic         made;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    task_index_i   <= idx;
    arrival_time_i <= arr;
    burst_length_i <= burst;
    advance_schedule(m, idx, arr, burst, predicted, made);
    if (made) pending_reports.push_back(typed ? given : predicted);
    items_sent++;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  // hold off until every tick report is out and the block has gone quiet
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_idx, input time_t data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= reg_idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (reg_idx)
      CFG_TASK_COUNT: count_reg = data[COUNT_W-1:0];
      CFG_QUANTUM:    quantum_reg = data[QUANTUM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_episode();
    logic [COUNT_W-1:0] cnt;
    time_t              data;
    if ($urandom_range(9) < 3) begin
      settle_block();
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(9))
          0:       cnt = '0;
          1:       cnt = COUNT_W'($urandom_range(17, 31));
          2:       cnt = COUNT_W'(NUM_TASKS);
          default: cnt = COUNT_W'($urandom_range(1, 6));
        endcase
        // upper data bits are don't-care for the count register
        data = time_t'($urandom);
        data[COUNT_W-1:0] = cnt;
        write_reg(CFG_TASK_COUNT, data);
      end
      case ($urandom_range(9))
        0:       write_reg(CFG_QUANTUM, '0);
        1:       write_reg(CFG_QUANTUM, '1);
        2:       write_reg(CFG_QUANTUM, time_t'($urandom));
        3, 4:    ;
        default: write_reg(CFG_QUANTUM, time_t'($urandom_range(1, 5)));
      endcase
    end else if ($urandom_range(19) == 0) begin
      settle_block();
    end
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 8))
        send_item(mode_t'($urandom), task_t'($urandom), time_t'($urandom), time_t'($urandom),
                  1'b0, '0);
    end else begin
      // a few loads, or none to carry on the current schedule, then a run of ticks
      repeat ($urandom_range(0, 4))
        send_item(MODE_LOAD, task_t'($urandom),
                  ($urandom_range(9) == 0) ? time_t'($urandom) : time_t'($urandom_range(0, 30)),
                  ($urandom_range(19) == 0) ? time_t'($urandom) : time_t'($urandom_range(0, 8)),
                  1'b0, '0);
      repeat ($urandom_range(4, 40))
        send_item(MODE_TICK, task_t'($urandom), time_t'($urandom), time_t'($urandom), 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  always @(negedge clk_i) begin : report_check
    tick_report_t got;
    tick_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.tick_no   = tick_number_o;
      got.busy      = busy_res_o;
      got.run_task  = running_task_o;
      got.ret_valid = retired_valid_o;
      got.ret_task  = retired_task_o;
      got.compl     = completion_time_o;
      got.turn      = turnaround_time_o;
      got.waiting   = waiting_time_o;
      got.resp      = response_time_o;
      got.all_done  = all_done_o;
      if (pending_reports.size() == 0) begin
        error_count++;
        if (error_count <= MAX_SHOWN)
          $display("unexpected tick report: %s", report_text(got));
      end else begin
        want = pending_reports.pop_front();
        if (got.tick_no !== want.tick_no || got.busy !== want.busy ||
            got.run_task !== want.run_task || got.ret_valid !== want.ret_valid ||
            got.ret_task !== want.ret_task || got.compl !== want.compl ||
            got.turn !== want.turn || got.waiting !== want.waiting ||
            got.resp !== want.resp || got.all_done !== want.all_done) begin
          error_count++;
          if (error_count <= MAX_SHOWN) begin
            $display("tick report mismatch at %0t", $time);
            $display("  expected %s", report_text(want));
            $display("  actual   %s", report_text(got));
          end
        end
      end
    end
  end

  initial begin
    #TIMEOUT;
    $display("FAILURE");
    $finish;
  end

  initial begin
    plan_row_t   row;
    int unsigned stop_at;
    foreach (arrival_mem[i]) begin
      arrival_mem[i]   = '0;
      burst_mem[i]     = '0;
      first_run_mem[i] = '0;
    end
    count_reg   = TASK_COUNT_RST;
    quantum_reg = QUANTUM_RST;
    restart_schedule();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // write every entry so no tick ever reads an empty one
    for (int unsigned i = 0; i < NUM_TASKS; i++)
      send_item(MODE_LOAD, task_t'(i), time_t'($urandom_range(0, 12)),
                time_t'($urandom_range(0, 6)), 1'b0, '0);

    foreach (DIRECTED_PLAN[r]) begin
      row = DIRECTED_PLAN[r];
      case (row.kind)
        ROW_CFG: begin
          settle_block();
          write_reg(row.sel[CFG_IDX_W-1:0], row.a);
        end
        ROW_LOAD: send_item(MODE_LOAD, row.sel, row.a, row.b, row.typed, row.want);
        default:  send_item(MODE_TICK, row.sel, row.a, row.b, row.typed, row.want);
      endcase
    end

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      stop_at = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < stop_at) run_episode();
    end

    settle_block();
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/rrqs_pkg.sv
src/rrqs_ram.sv
src/rrqs_ctrl.sv
src/rrqs_dp.sv
src/round_robin_quantum_scheduler_unit.sv
verif/round_robin_quantum_scheduler_unit_test.sv
